// ===== hw/rtl/edd4_pkg.sv =====
// Shared types, constants and helpers of the four-level error-diffusion ditherer.
`timescale 1ns / 1ps
`default_nettype none

package edd4_pkg;

    // Geometry and fixed-point format
    localparam int MAX_WIDTH    = 2048;
    localparam int MAX_CHANNELS = 4;
    localparam int ERR_FRAC     = 8;

    localparam int SAMPLE_W = 8;
    localparam int COL_W    = $clog2(MAX_WIDTH);
    localparam int CH_W     = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int ROW_W    = 16;

    // Stored error, accumulator, saturating sum and product widths
    localparam int ERR_W  = ERR_FRAC + 10;
    localparam int ACC_W  = ERR_W + 2;
    localparam int SUM_W  = ACC_W + 1;
    localparam int PROD_W = ACC_W + 4;

    // Error store: indexed {column, channel}, split into even/odd column banks
    localparam int STORE_IDX_W = COL_W + CH_W;
    localparam int BANK_DEPTH  = (MAX_WIDTH / 2) * (1 << CH_W);

    // Configuration register file
    localparam int WREG_W     = 12;
    localparam int HREG_W     = 16;
    localparam int NREG_W     = 3;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = CFG_IDX_W'(2);

    localparam logic [WREG_W-1:0] WIDTH_RESET   = WREG_W'(640);
    localparam logic [HREG_W-1:0] HEIGHT_RESET  = HREG_W'(480);
    localparam logic [NREG_W-1:0] CHANNEL_RESET = NREG_W'(3);

    // Quantizer thresholds 42.5, 127.5, 212.5 in fixed point
    localparam int HALF = 1 << (ERR_FRAC - 1);
    localparam logic signed [ACC_W-1:0] TH_LOW  = ACC_W'(85 * HALF);
    localparam logic signed [ACC_W-1:0] TH_MID  = ACC_W'(255 * HALF);
    localparam logic signed [ACC_W-1:0] TH_HIGH = ACC_W'(425 * HALF);

    // Floyd-Steinberg weights, in sixteenths
    localparam int SHARE_SHIFT = 4;
    localparam logic [3:0] W_RIGHT = 4'd7;
    localparam logic [3:0] W_BLEFT = 4'd3;
    localparam logic [3:0] W_BELOW = 4'd5;
    localparam logic [3:0] W_BRGHT = 4'd1;

    localparam logic signed [SUM_W-1:0] ERR_HI = SUM_W'((1 << (ERR_W - 1)) - 1);
    localparam logic signed [SUM_W-1:0] ERR_LO = -ERR_HI - SUM_W'(1);

    typedef logic [1:0] level_code_t;

    localparam level_code_t LVL_0   = 2'd0;
    localparam level_code_t LVL_85  = 2'd1;
    localparam level_code_t LVL_170 = 2'd2;
    localparam level_code_t LVL_255 = 2'd3;

    // Stream position of one sample
    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [CH_W-1:0]  ch;
        logic             row_nz;
        logic             last_col;
        logic             frame_end;
    } pos_t;

    // Error store writes issued for one sample
    typedef struct packed {
        logic                    prev_en;
        logic [STORE_IDX_W-1:0]  prev_idx;
        logic signed [ERR_W-1:0] prev_data;
        logic                    last_en;
        logic [STORE_IDX_W-1:0]  last_idx;
        logic signed [ERR_W-1:0] last_data;
    } wr_t;

    function automatic logic signed [ERR_W-1:0] sat_err(input logic signed [SUM_W-1:0] v);
        logic signed [ERR_W-1:0] r;
        if (v > ERR_HI)
            r = ERR_W'(ERR_HI);
        else if (v < ERR_LO)
            r = ERR_W'(ERR_LO);
        else
            r = ERR_W'(v);
        return r;
    endfunction

    // floor((err*k + 8) / 16)
    function automatic logic signed [ACC_W-1:0] share(input logic signed [ACC_W-1:0] err,
                                                      input logic [3:0] k);
        logic signed [PROD_W-1:0] e;
        logic signed [PROD_W-1:0] kk;
        logic signed [PROD_W-1:0] p;
        e  = PROD_W'(err);
        kk = PROD_W'(k);
        p  = e * kk + PROD_W'(1 << (SHARE_SHIFT - 1));
        return ACC_W'(p >>> SHARE_SHIFT);
    endfunction

    function automatic logic [SAMPLE_W-1:0] level_value(input level_code_t code);
        logic [SAMPLE_W-1:0] v;
        unique case (code)
            LVL_0:   v = SAMPLE_W'(0);
            LVL_85:  v = SAMPLE_W'(85);
            LVL_170: v = SAMPLE_W'(170);
            LVL_255: v = SAMPLE_W'(255);
            default: v = SAMPLE_W'(0);
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/error_diffusion_dither_4level_top.sv =====
// Top level of the four-level Floyd-Steinberg ditherer: pipeline, store banks, forwarding.
// A sample accepted into stage 1 is quantized when stage 1 fires, and its level is
//   registered into the output register, where it is held while the result side stalls.
// Throughput: one sample per clock while the result side does not stall; the store read
//   on acceptance and the store update when stage 1 fires overlap across samples.
// Stall on the result side holds the pipeline; one sample waits in stage 1.
// Reset clears position, carry registers and registers to 640 x 480 x 3; the error
//   store needs no clearing since row 0 never uses what it reads.
`timescale 1ns / 1ps
`default_nettype none

module error_diffusion_dither_4level_top
    import edd4_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_write,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  sample_valid,
    output logic                       sample_stall,
    input  wire logic [SAMPLE_W-1:0]   sample_in,
    output logic                       level_valid,
    input  wire logic                  level_stall,
    output logic [SAMPLE_W-1:0]        level_out,
    output logic                       frame_end
);

    localparam int BANK_AW = $clog2(BANK_DEPTH);

    pos_t pos, s1_pos_reg;
    wr_t  wr;

    logic                    accept, s1_fire;
    logic                    s1_valid_reg, s1_valid_next;
    logic [SAMPLE_W-1:0]     s1_sample_reg;
    logic                    fwd_hit_reg, fwd_hit_next;
    logic signed [ERR_W-1:0] fwd_data_reg, fwd_data_next;
    logic                    out_valid_reg, out_valid_next;
    logic [SAMPLE_W-1:0]     level_reg, level_s1;
    logic                    frame_end_reg;

    logic [STORE_IDX_W-1:0]  rd_idx;
    logic [BANK_AW-1:0]      raddr;
    logic [ERR_W-1:0]        rdata0, rdata1;
    logic signed [ERR_W-1:0] store_val;

    logic                    we0, we1;
    logic [BANK_AW-1:0]      waddr0, waddr1;
    logic [ERR_W-1:0]        wdata0, wdata1;
    logic                    prev_odd, last_odd;

    edd4_scan u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .advance   (accept),
        .pos       (pos)
    );

    assign s1_fire      = s1_valid_reg && (!out_valid_reg || !level_stall);
    assign sample_stall = s1_valid_reg && !s1_fire;
    assign accept       = sample_valid && !sample_stall;

    assign rd_idx = {pos.col, pos.ch};
    assign raddr  = {pos.col[COL_W-1:1], pos.ch};

    // Bank select is column parity; the two writes of a sample never share a bank
    assign prev_odd = wr.prev_idx[CH_W];
    assign last_odd = wr.last_idx[CH_W];

    always_comb
    begin
        we0    = (wr.prev_en && !prev_odd) || (wr.last_en && !last_odd);
        we1    = (wr.prev_en && prev_odd) || (wr.last_en && last_odd);
        waddr0 = (wr.prev_en && !prev_odd)
               ? {wr.prev_idx[STORE_IDX_W-1:CH_W+1], wr.prev_idx[CH_W-1:0]}
               : {wr.last_idx[STORE_IDX_W-1:CH_W+1], wr.last_idx[CH_W-1:0]};
        waddr1 = (wr.prev_en && prev_odd)
               ? {wr.prev_idx[STORE_IDX_W-1:CH_W+1], wr.prev_idx[CH_W-1:0]}
               : {wr.last_idx[STORE_IDX_W-1:CH_W+1], wr.last_idx[CH_W-1:0]};
        wdata0 = (wr.prev_en && !prev_odd) ? wr.prev_data : wr.last_data;
        wdata1 = (wr.prev_en && prev_odd) ? wr.prev_data : wr.last_data;
    end

    edd4_ram #(
        .DEPTH (BANK_DEPTH),
        .WIDTH (ERR_W)
    ) u_bank_even (
        .clk   (clk),
        .we    (we0),
        .waddr (waddr0),
        .wdata (wdata0),
        .re    (accept),
        .raddr (raddr),
        .rdata (rdata0)
    );

    edd4_ram #(
        .DEPTH (BANK_DEPTH),
        .WIDTH (ERR_W)
    ) u_bank_odd (
        .clk   (clk),
        .we    (we1),
        .waddr (waddr1),
        .wdata (wdata1),
        .re    (accept),
        .raddr (raddr),
        .rdata (rdata1)
    );

    // Same-cycle write to the entry being read: bypass the RAM's old data
    always_comb
    begin
        fwd_hit_next  = 1'b0;
        fwd_data_next = wr.prev_data;
        if (wr.prev_en && wr.prev_idx == rd_idx)
        begin
            fwd_hit_next  = 1'b1;
            fwd_data_next = wr.prev_data;
        end
        else if (wr.last_en && wr.last_idx == rd_idx)
        begin
            fwd_hit_next  = 1'b1;
            fwd_data_next = wr.last_data;
        end
    end

    assign store_val = fwd_hit_reg ? fwd_data_reg
                     : (s1_pos_reg.col[0] ? $signed(rdata1) : $signed(rdata0));

    edd4_quant u_quant (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (s1_fire),
        .pos       (s1_pos_reg),
        .sample    (s1_sample_reg),
        .store_val (store_val),
        .level     (level_s1),
        .wr        (wr)
    );

    always_comb
    begin
        s1_valid_next  = accept ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_reg);
        out_valid_next = s1_fire ? 1'b1 : (level_stall ? out_valid_reg : 1'b0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pos_reg    <= pos;
            s1_sample_reg <= sample_in;
            fwd_hit_reg   <= fwd_hit_next;
            fwd_data_reg  <= fwd_data_next;
        end
        if (s1_fire)
        begin
            level_reg     <= level_s1;
            frame_end_reg <= s1_pos_reg.frame_end;
        end
    end

    assign level_valid = out_valid_reg;
    assign level_out   = level_reg;
    assign frame_end   = frame_end_reg;

    a_fire_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire |=> out_valid_reg)
        else $error("stage 1 result lost");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        accept && s1_valid_reg |-> s1_fire)
        else $error("stage 1 overwritten while held");

    a_banks_split: assert property (@(posedge clk) disable iff (!rst_n)
        wr.prev_en && wr.last_en |-> prev_odd != last_odd)
        else $error("two store writes to one bank");

    a_level_legal: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire |=> (level_reg == 8'd0 || level_reg == 8'd85 ||
                     level_reg == 8'd170 || level_reg == 8'd255))
        else $error("level out of set");

endmodule

`default_nettype wire

// ===== hw/rtl/edd4_ram.sv =====
// Simple dual-port RAM, one write and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module edd4_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 18
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read during write to the same entry returns old data
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/edd4_scan.sv =====
// Configuration registers and raster position counters.
`timescale 1ns / 1ps
`default_nettype none

module edd4_scan
    import edd4_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_write,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  advance,
    output pos_t                       pos
);

    logic [WREG_W-1:0] width_reg;
    logic [HREG_W-1:0] height_reg;
    logic [NREG_W-1:0] nch_reg;

    logic [COL_W-1:0] col_reg, col_next;
    logic [CH_W-1:0]  ch_reg, ch_next;
    logic [ROW_W-1:0] row_reg, row_next;

    logic [WREG_W-1:0] w_eff;
    logic [HREG_W-1:0] h_eff;
    logic [NREG_W-1:0] nc_eff;
    logic              last_col, last_ch, last_row;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            nch_reg    <= CHANNEL_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:   width_reg  <= cfg_data[WREG_W-1:0];
                REG_IMAGE_HEIGHT:  height_reg <= cfg_data[HREG_W-1:0];
                REG_CHANNEL_COUNT: nch_reg    <= cfg_data[NREG_W-1:0];
                default:           ;
            endcase
        end
    end

    // Clamp out-of-range settings
    always_comb
    begin
        if (width_reg == '0)
            w_eff = WREG_W'(1);
        else if (width_reg > WREG_W'(MAX_WIDTH))
            w_eff = WREG_W'(MAX_WIDTH);
        else
            w_eff = width_reg;

        h_eff = (height_reg == '0) ? HREG_W'(1) : height_reg;

        if (nch_reg == '0)
            nc_eff = NREG_W'(1);
        else if (nch_reg > NREG_W'(MAX_CHANNELS))
            nc_eff = NREG_W'(MAX_CHANNELS);
        else
            nc_eff = nch_reg;
    end

    always_comb
    begin
        last_col = (WREG_W'(col_reg) + WREG_W'(1)) >= w_eff;
        last_ch  = (NREG_W'(ch_reg) + NREG_W'(1)) >= nc_eff;
        last_row = ({1'b0, row_reg} + (ROW_W + 1)'(1)) >= {1'b0, h_eff};

        col_next = col_reg;
        ch_next  = ch_reg;
        row_next = row_reg;
        if (!last_ch)
        begin
            ch_next = ch_reg + CH_W'(1);
        end
        else
        begin
            ch_next = '0;
            if (!last_col)
            begin
                col_next = col_reg + COL_W'(1);
            end
            else
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + ROW_W'(1);
            end
        end

        pos.col       = col_reg;
        pos.ch        = ch_reg;
        pos.row_nz    = (row_reg != '0);
        pos.last_col  = last_col;
        pos.frame_end = last_col && last_ch && last_row;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            ch_reg  <= '0;
            row_reg <= '0;
        end
        else if (advance)
        begin
            col_reg <= col_next;
            ch_reg  <= ch_next;
            row_reg <= row_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/edd4_quant.sv =====
// Quantizer and error distribution with the per-channel carry registers.
`timescale 1ns / 1ps
`default_nettype none

module edd4_quant
    import edd4_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    fire,
    input  wire pos_t                    pos,
    input  wire logic [SAMPLE_W-1:0]     sample,
    input  wire logic signed [ERR_W-1:0] store_val,
    output logic [SAMPLE_W-1:0]          level,
    output wr_t                          wr
);

    logic signed [ERR_W-1:0] right_reg [MAX_CHANNELS];
    logic signed [ERR_W-1:0] bp0_reg   [MAX_CHANNELS];
    logic signed [ERR_W-1:0] bp1_reg   [MAX_CHANNELS];

    logic signed [ACC_W-1:0] acc, err, lvl_fx;
    logic signed [ACC_W-1:0] b7, b3, b5, b1;
    logic signed [ERR_W-1:0] p0, p1, new0;
    logic signed [ERR_W-1:0] right_next, bp0_next, bp1_next;
    level_code_t             code;
    logic                    col_nz;

    always_comb
    begin
        col_nz = (pos.col != '0);

        acc = $signed({{(ACC_W - SAMPLE_W - ERR_FRAC){1'b0}}, sample, {ERR_FRAC{1'b0}}});
        if (pos.row_nz)
            acc = acc + ACC_W'(store_val);
        if (col_nz)
            acc = acc + ACC_W'(right_reg[pos.ch]);

        priority if (acc < TH_LOW)
            code = LVL_0;
        else if (acc < TH_MID)
            code = LVL_85;
        else if (acc < TH_HIGH)
            code = LVL_170;
        else
            code = LVL_255;

        level  = level_value(code);
        lvl_fx = $signed({{(ACC_W - SAMPLE_W - ERR_FRAC){1'b0}}, level, {ERR_FRAC{1'b0}}});
        err    = acc - lvl_fx;

        b7 = share(err, W_RIGHT);
        b3 = share(err, W_BLEFT);
        b5 = share(err, W_BELOW);
        b1 = pos.last_col ? '0 : share(err, W_BRGHT);

        p0   = bp0_reg[pos.ch];
        p1   = bp1_reg[pos.ch];
        new0 = sat_err(SUM_W'(p1) + SUM_W'(b5));

        right_next = pos.last_col ? '0 : sat_err(SUM_W'(b7));
        bp0_next   = pos.last_col ? '0 : new0;
        bp1_next   = sat_err(SUM_W'(b1));

        // Below-left share completes the entry one column back
        wr.prev_en   = fire && col_nz;
        wr.prev_idx  = {pos.col - COL_W'(1), pos.ch};
        wr.prev_data = sat_err(SUM_W'(p0) + SUM_W'(b3));
        // Last column flushes its own partial sum
        wr.last_en   = fire && pos.last_col;
        wr.last_idx  = {pos.col, pos.ch};
        wr.last_data = new0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_CHANNELS; i++)
            begin
                right_reg[i] <= '0;
                bp0_reg[i]   <= '0;
                bp1_reg[i]   <= '0;
            end
        end
        else if (fire)
        begin
            right_reg[pos.ch] <= right_next;
            bp0_reg[pos.ch]   <= bp0_next;
            bp1_reg[pos.ch]   <= bp1_next;
        end
    end

endmodule

`default_nettype wire
